FILE: design/anc_pkg.sv
// shared types and constants for the arp neighbor cache
`timescale 1ns / 1ps
package anc_pkg;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] ip_address;
		logic [47:0] mac_address;
		logic [31:0] target_ip;
		logic        is_request;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] ip_out;
		logic [47:0] mac_out;
		logic        last;
	} out_beat_t;

	typedef struct packed {
		logic [31:0] my_ip;
		logic [15:0] entry_expire_ticks;
		logic [15:0] request_expire_ticks;
		logic [7:0]  max_requests;
	} cfg_t;

	localparam logic [1:0] OP_ARP    = 2'd0;
	localparam logic [1:0] OP_FILL   = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;
	localparam logic [1:0] OP_TICK   = 2'd3;

	localparam logic [2:0] ACT_NONE       = 3'd0;
	localparam logic [2:0] ACT_KNOWN      = 3'd1;
	localparam logic [2:0] ACT_REQUEST    = 3'd2;
	localparam logic [2:0] ACT_REPLY      = 3'd3;
	localparam logic [2:0] ACT_UNRESOLVED = 3'd4;
	localparam logic [2:0] ACT_FULL       = 3'd5;

	localparam logic [1:0] REG_MY_IP       = 2'd0;
	localparam logic [1:0] REG_ENTRY_EXP   = 2'd1;
	localparam logic [1:0] REG_REQUEST_EXP = 2'd2;
	localparam logic [1:0] REG_MAX_REQ     = 2'd3;

	localparam logic [47:0] MAC_UNRES   = 48'hFFFF_FFFF_FFFF;
	localparam logic [7:0]  CNT_MAX     = 8'hFF;
	localparam logic [4:0]  MAX_RESULTS = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_EV,
		ST_DEC,
		ST_REPLY,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic ev;
		logic dec;
		logic reply;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
		logic is_tick;
		logic ev_stall;
		logic dec_stall;
		logic rep_stall;
		logic out_free;
	} sts_t;

endpackage

FILE: design/anc_ctrl.sv
// sequencer for scan, decision, reply and result flush
`timescale 1ns / 1ps
module anc_ctrl import anc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = ST_RD;
			end
			ST_RD: state_nx = ST_EV;
			ST_EV: begin
				if (!sts.ev_stall) begin
					if (!sts.idx_last) state_nx = ST_RD;
					else if (sts.is_tick) state_nx = ST_FLUSH;
					else state_nx = ST_DEC;
				end
			end
			ST_DEC: begin
				if (!sts.dec_stall) state_nx = ST_REPLY;
			end
			ST_REPLY: begin
				if (!sts.rep_stall) state_nx = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (sts.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_RD:    cmd.rd = 1'b1;
			ST_EV:    cmd.ev = 1'b1;
			ST_DEC:   cmd.dec = 1'b1;
			ST_REPLY: cmd.reply = 1'b1;
			ST_FLUSH: cmd.flush = 1'b1;
			default:  cmd = '0;
		endcase
	end

endmodule

FILE: design/anc_dp.sv
// entry table, scan registers and result registers
`timescale 1ns / 1ps
module anc_dp import anc_pkg::*; #(
	parameter int TABLE_DEPTH = 16,
	parameter int TIMER_BITS  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  in_beat_t  in_data,
	input  cmd_t      cmd,
	output sts_t      sts,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [32:0] TMAX = 33'((64'd1 << TIMER_BITS) - 64'd1);

	typedef struct packed {
		logic [31:0]           ip;
		logic [47:0]           mac;
		logic                  in_use;
		logic [7:0]            cnt;
		logic [TIMER_BITS-1:0] timer;
	} entry_t;

	function automatic logic [TIMER_BITS-1:0] reload(input logic [15:0] v);
		logic [TIMER_BITS-1:0] r;
		if ({17'd0, v} > TMAX) r = TMAX[TIMER_BITS-1:0];
		else r = TIMER_BITS'(v);
		return r;
	endfunction

	function automatic logic [7:0] count_up(input logic [7:0] c);
		return (c == CNT_MAX) ? CNT_MAX : c + 8'd1;
	endfunction

	entry_t                 mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	entry_t                 rd_q;
	in_beat_t               in_q;
	logic [IW-1:0]          idx_q;
	logic                   hit_q, free_q;
	logic [IW-1:0]          hit_idx_q, free_idx_q;
	entry_t                 hit_q_ent;
	logic [4:0]             emit_cnt_q;
	out_beat_t              pend_q, out_q;
	logic                   pend_v_q, out_v_q;

	logic          emit_ok, can_push, out_free;
	logic          cur_valid;
	logic [TIMER_BITS-1:0] t_dec;
	logic          renew;
	logic          ev_push, dec_push, rep_push;
	logic          ev_go, dec_go, rep_go, push_go, flush_go;
	out_beat_t     dec_beat, push_beat;
	logic          learn, tip_me;
	logic          wr_en, set_valid, clr_valid;
	logic [IW-1:0] wr_idx;
	entry_t        wr_data, dec_wr;
	logic          dec_wr_en, dec_set;
	logic [IW-1:0] dec_idx;

	assign emit_ok  = emit_cnt_q < MAX_RESULTS;
	assign out_free = !out_v_q || out_ready;
	assign can_push = !pend_v_q || out_free;
	assign cur_valid = valid_q[idx_q];
	assign tip_me   = in_q.target_ip == cfg.my_ip;

	// tick evaluation of the entry just read
	assign t_dec = (rd_q.timer == '0) ? '0 : rd_q.timer - 1'b1;
	assign renew = rd_q.in_use || (rd_q.cnt != 8'd0 && rd_q.cnt <= cfg.max_requests);
	assign ev_push = (in_q.opcode == OP_TICK) && cur_valid && (t_dec == '0) && renew
		&& emit_ok;

	assign learn = tip_me || (in_q.target_ip == 32'd0 && hit_q);

	always_comb begin
		dec_push  = 1'b0;
		dec_beat  = '{action: ACT_NONE, ip_out: in_q.ip_address, mac_out: 48'd0, last: 1'b0};
		dec_wr_en = 1'b0;
		dec_set   = 1'b0;
		dec_idx   = hit_idx_q;
		dec_wr    = hit_q_ent;
		unique case (in_q.opcode)
			OP_ARP: begin
				dec_wr = '{ip: in_q.ip_address, mac: in_q.mac_address, in_use: 1'b0,
					cnt: 8'd0, timer: reload(cfg.entry_expire_ticks)};
				if (learn) begin
					if (hit_q) begin
						dec_wr_en = 1'b1;
					end else if (free_q) begin
						dec_wr_en = 1'b1;
						dec_set   = 1'b1;
						dec_idx   = free_idx_q;
					end else begin
						dec_push = 1'b1;
						dec_beat.action = ACT_FULL;
					end
				end
			end
			OP_FILL: begin
				dec_push = 1'b1;
				if (hit_q) begin
					if (hit_q_ent.mac != MAC_UNRES) begin
						dec_beat.action  = ACT_KNOWN;
						dec_beat.mac_out = hit_q_ent.mac;
					end else begin
						dec_wr_en = 1'b1;
						dec_wr.cnt   = count_up(hit_q_ent.cnt);
						dec_wr.timer = reload(cfg.request_expire_ticks);
						dec_beat.action  = ACT_REQUEST;
						dec_beat.mac_out = MAC_UNRES;
					end
				end else if (free_q) begin
					dec_wr_en = 1'b1;
					dec_set   = 1'b1;
					dec_idx   = free_idx_q;
					dec_wr = '{ip: in_q.ip_address, mac: MAC_UNRES, in_use: 1'b0,
						cnt: 8'd1, timer: reload(cfg.request_expire_ticks)};
					dec_beat.action  = ACT_REQUEST;
					dec_beat.mac_out = MAC_UNRES;
				end else begin
					dec_beat.action = ACT_FULL;
				end
			end
			OP_LOOKUP: begin
				dec_push = 1'b1;
				dec_beat.action  = ACT_UNRESOLVED;
				dec_beat.mac_out = MAC_UNRES;
				if (hit_q) begin
					dec_wr_en = 1'b1;
					dec_wr.in_use = 1'b1;
					if (hit_q_ent.mac != MAC_UNRES) begin
						dec_beat.action  = ACT_KNOWN;
						dec_beat.mac_out = hit_q_ent.mac;
					end
				end
			end
			OP_TICK: dec_push = 1'b0;
			default: dec_push = 1'b0;
		endcase
	end

	assign rep_push = (in_q.opcode == OP_ARP) && in_q.is_request && tip_me && emit_ok;

	assign sts.ev_stall  = ev_push && !can_push;
	assign sts.dec_stall = dec_push && emit_ok && !can_push;
	assign sts.rep_stall = rep_push && !can_push;
	assign sts.idx_last  = idx_q == IW'(TABLE_DEPTH - 1);
	assign sts.is_tick   = in_q.opcode == OP_TICK;
	assign sts.out_free  = out_free;

	assign ev_go    = cmd.ev && !sts.ev_stall;
	assign dec_go   = cmd.dec && !sts.dec_stall;
	assign rep_go   = cmd.reply && !sts.rep_stall;
	assign flush_go = cmd.flush && out_free;

	always_comb begin
		push_go   = 1'b0;
		push_beat = dec_beat;
		if (ev_go && ev_push) begin
			push_go   = 1'b1;
			push_beat = '{action: ACT_REQUEST, ip_out: rd_q.ip, mac_out: MAC_UNRES, last: 1'b0};
		end else if (dec_go && dec_push && emit_ok) begin
			push_go = 1'b1;
		end else if (rep_go && rep_push) begin
			push_go   = 1'b1;
			push_beat = '{action: ACT_REPLY, ip_out: in_q.ip_address,
				mac_out: in_q.mac_address, last: 1'b0};
		end
	end

	// single table write port
	always_comb begin
		wr_en     = 1'b0;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		wr_idx    = idx_q;
		wr_data   = rd_q;
		if (ev_go && sts.is_tick && cur_valid) begin
			if (t_dec != '0) begin
				wr_en = 1'b1;
				wr_data.timer = t_dec;
			end else if (renew) begin
				wr_en = 1'b1;
				wr_data.timer  = reload(cfg.request_expire_ticks);
				wr_data.in_use = 1'b0;
				wr_data.cnt    = count_up(rd_q.cnt);
			end else begin
				clr_valid = 1'b1;
			end
		end else if (dec_go) begin
			wr_en     = dec_wr_en;
			set_valid = dec_set;
			wr_idx    = dec_idx;
			wr_data   = dec_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_idx] <= wr_data;
		if (cmd.rd) rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (set_valid) valid_q[wr_idx] <= 1'b1;
			if (clr_valid) valid_q[wr_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= in_data;
		if (ev_go && cur_valid && rd_q.ip == in_q.ip_address && !hit_q) begin
			hit_idx_q <= idx_q;
			hit_q_ent <= rd_q;
		end
		if (ev_go && !cur_valid && !free_q) free_idx_q <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			emit_cnt_q <= '0;
		end else if (cmd.load) begin
			idx_q      <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			emit_cnt_q <= '0;
		end else begin
			if (ev_go && !sts.idx_last) idx_q <= idx_q + 1'b1;
			if (ev_go && cur_valid && rd_q.ip == in_q.ip_address) hit_q <= 1'b1;
			if (ev_go && !cur_valid) free_q <= 1'b1;
			if (push_go) emit_cnt_q <= emit_cnt_q + 5'd1;
		end
	end

	// pending beat holds back the newest result until its last flag is known
	always_ff @(posedge clk) begin
		if (push_go) pend_q <= push_beat;
		if (flush_go) begin
			if (pend_v_q) out_q <= '{action: pend_q.action, ip_out: pend_q.ip_out,
				mac_out: pend_q.mac_out, last: 1'b1};
			else out_q <= '{action: ACT_NONE, ip_out: in_q.ip_address, mac_out: 48'd0,
				last: 1'b1};
		end else if (push_go && pend_v_q) begin
			out_q <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (flush_go) pend_v_q <= 1'b0;
			else if (push_go) pend_v_q <= 1'b1;
			if (flush_go || (push_go && pend_v_q)) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

FILE: design/arp_neighbor_cache.sv
// top level of the arp neighbor cache: register port, sequencer and table
//
//  channel | dir | handshake            | beat
//  in      | in  | in_valid / in_ready  | in_beat_t (opcode, addresses, request flag)
//  out     | out | out_valid/out_ready  | out_beat_t (action, ip, mac, last)
//  apb     | in  | psel/penable/pready  | 32-bit register write or read
//
// every item scans the whole table, one entry at a time through the single table
// read port (read state, then evaluate state), then a tick goes to flush and other
// items pass decision and reply first; out can stall them; one item is in work at a time
// reset clears the valid bits at once, no clearing pass is needed
// a full result register and a full pending beat hold the scan until out drains
`timescale 1ns / 1ps
module arp_neighbor_cache import anc_pkg::*; #(
	parameter int TABLE_DEPTH = 16,
	parameter int TIMER_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_beat_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_beat_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic wr_go;

	assign pready = 1'b1;
	assign wr_go  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.my_ip                <= 32'd0;
			cfg_q.entry_expire_ticks   <= 16'd60000;
			cfg_q.request_expire_ticks <= 16'd1000;
			cfg_q.max_requests         <= 8'd3;
		end else if (wr_go) begin
			unique case (paddr[3:2])
				REG_MY_IP:       cfg_q.my_ip <= pwdata;
				REG_ENTRY_EXP:   cfg_q.entry_expire_ticks <= pwdata[15:0];
				REG_REQUEST_EXP: cfg_q.request_expire_ticks <= pwdata[15:0];
				REG_MAX_REQ:     cfg_q.max_requests <= pwdata[7:0];
				default:         cfg_q.max_requests <= cfg_q.max_requests;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MY_IP:       prdata = cfg_q.my_ip;
			REG_ENTRY_EXP:   prdata = {16'd0, cfg_q.entry_expire_ticks};
			REG_REQUEST_EXP: prdata = {16'd0, cfg_q.request_expire_ticks};
			REG_MAX_REQ:     prdata = {24'd0, cfg_q.max_requests};
			default:         prdata = 32'd0;
		endcase
	end

	anc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	anc_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.TIMER_BITS  (TIMER_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: design/anc_checker.sv
// port-level checks for the arp neighbor cache
`timescale 1ns / 1ps
module anc_checker import anc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_beat_t out_data,
	input logic      pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out beat dropped while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new item taken while previous one in work");

	a_action_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.action <= ACT_FULL)
		else $error("action code out of range");

	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.action == ACT_NONE |-> out_data.last)
		else $error("empty result not marked last");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("register port not ready");

endmodule

bind arp_neighbor_cache anc_checker u_anc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.pready    (pready)
);

FILE: tb/tb_top.sv
// self-checking testbench for the arp neighbor cache with a behavioral predictor
`timescale 1ns / 1ps
module tb_top;
	import anc_pkg::*;

	localparam int DEPTH = 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_beat_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_beat_t   out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	arp_neighbor_cache i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor copy of the registers and table
	logic [31:0] cfg_my_ip;
	logic [15:0] cfg_entry_exp;
	logic [15:0] cfg_req_exp;
	logic [7:0]  cfg_max_req;
	logic        tbl_valid [DEPTH];
	logic [31:0] tbl_ip [DEPTH];
	logic [47:0] tbl_mac [DEPTH];
	logic        tbl_in_use [DEPTH];
	logic [7:0]  tbl_count [DEPTH];
	logic [15:0] tbl_timer [DEPTH];

	out_beat_t expected_beats [$];
	int  errors = 0;
	bit  hold_off = 1'b0;
	logic [31:0] ip_pool [8];

	function automatic logic [7:0] sat_inc(logic [7:0] c);
		return (c == CNT_MAX) ? CNT_MAX : c + 8'd1;
	endfunction

	function automatic int find_entry(logic [31:0] ip);
		for (int i = 0; i < DEPTH; i++)
			if (tbl_valid[i] && tbl_ip[i] == ip)
				return i;
		return -1;
	endfunction

	function automatic int free_entry();
		for (int i = 0; i < DEPTH; i++)
			if (!tbl_valid[i])
				return i;
		return -1;
	endfunction

	task automatic push_beat(ref out_beat_t batch [$], input logic [2:0] act,
			input logic [31:0] ip, input logic [47:0] mac);
		out_beat_t b;
		if (batch.size() >= 16)
			return;
		b.action = act;
		b.ip_out = ip;
		b.mac_out = mac;
		b.last = 1'b0;
		batch.push_back(b);
	endtask

	task automatic predict_cache(input in_beat_t it);
		out_beat_t batch [$];
		int s;
		if (it.opcode == OP_ARP) begin
			if (it.target_ip == cfg_my_ip ||
					(it.target_ip == 0 && find_entry(it.ip_address) >= 0)) begin
				s = find_entry(it.ip_address);
				if (s < 0) begin
					s = free_entry();
					if (s >= 0) begin
						tbl_valid[s] = 1'b1;
						tbl_ip[s] = it.ip_address;
					end
				end
				if (s < 0) begin
					push_beat(batch, ACT_FULL, it.ip_address, '0);
				end else begin
					tbl_mac[s] = it.mac_address;
					tbl_timer[s] = cfg_entry_exp;
					tbl_in_use[s] = 1'b0;
					tbl_count[s] = '0;
				end
			end
			if (it.is_request && it.target_ip == cfg_my_ip)
				push_beat(batch, ACT_REPLY, it.ip_address, it.mac_address);
		end else if (it.opcode == OP_FILL) begin
			s = find_entry(it.ip_address);
			if (s >= 0) begin
				if (tbl_mac[s] != MAC_UNRES) begin
					push_beat(batch, ACT_KNOWN, it.ip_address, tbl_mac[s]);
				end else begin
					tbl_count[s] = sat_inc(tbl_count[s]);
					tbl_timer[s] = cfg_req_exp;
					push_beat(batch, ACT_REQUEST, it.ip_address, MAC_UNRES);
				end
			end else begin
				s = free_entry();
				if (s < 0) begin
					push_beat(batch, ACT_FULL, it.ip_address, '0);
				end else begin
					tbl_valid[s] = 1'b1;
					tbl_ip[s] = it.ip_address;
					tbl_mac[s] = MAC_UNRES;
					tbl_in_use[s] = 1'b0;
					tbl_count[s] = 8'd1;
					tbl_timer[s] = cfg_req_exp;
					push_beat(batch, ACT_REQUEST, it.ip_address, MAC_UNRES);
				end
			end
		end else if (it.opcode == OP_LOOKUP) begin
			s = find_entry(it.ip_address);
			if (s >= 0) begin
				tbl_in_use[s] = 1'b1;
				if (tbl_mac[s] != MAC_UNRES)
					push_beat(batch, ACT_KNOWN, it.ip_address, tbl_mac[s]);
				else
					push_beat(batch, ACT_UNRESOLVED, it.ip_address, MAC_UNRES);
			end else begin
				push_beat(batch, ACT_UNRESOLVED, it.ip_address, MAC_UNRES);
			end
		end else begin
			for (int i = 0; i < DEPTH; i++) begin
				if (!tbl_valid[i])
					continue;
				if (tbl_timer[i] != 0)
					tbl_timer[i]--;
				if (tbl_timer[i] != 0)
					continue;
				if (tbl_in_use[i] || (tbl_count[i] > 0 && tbl_count[i] <= cfg_max_req)) begin
					tbl_timer[i] = cfg_req_exp;
					tbl_in_use[i] = 1'b0;
					tbl_count[i] = sat_inc(tbl_count[i]);
					push_beat(batch, ACT_REQUEST, tbl_ip[i], MAC_UNRES);
				end else begin
					tbl_valid[i] = 1'b0;
					tbl_in_use[i] = 1'b0;
					tbl_count[i] = '0;
					tbl_timer[i] = '0;
				end
			end
		end
		if (batch.size() == 0)
			push_beat(batch, ACT_NONE, it.ip_address, '0);
		batch[batch.size() - 1].last = 1'b1;
		foreach (batch[k])
			expected_beats.push_back(batch[k]);
	endtask

	task automatic random_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		repeat (n) @(posedge clk);
	endtask

	task automatic send_item(input in_beat_t it);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_cache(it);
		in_valid <= 1'b0;
		random_gap();
	endtask

	task automatic send_op(input logic [1:0] op, input logic [31:0] ip,
			input logic [47:0] mac, input logic [31:0] tip, input logic req);
		in_beat_t it;
		it.opcode = op;
		it.ip_address = ip;
		it.mac_address = mac;
		it.target_ip = tip;
		it.is_request = req;
		send_item(it);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (expected_beats.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MY_IP:       cfg_my_ip = val;
			REG_ENTRY_EXP:   cfg_entry_exp = val[15:0];
			REG_REQUEST_EXP: cfg_req_exp = val[15:0];
			default:         cfg_max_req = val[7:0];
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] ip, input logic [15:0] ee,
			input logic [15:0] re, input logic [7:0] mr);
		drain();
		write_reg(REG_MY_IP, ip);
		write_reg(REG_ENTRY_EXP, {16'h0, ee});
		write_reg(REG_REQUEST_EXP, {16'h0, re});
		write_reg(REG_MAX_REQ, {24'h0, mr});
	endtask

	task automatic test_directed();
		set_config(32'hC0A8_0001, 16'd3, 16'd1, 8'd2);
		send_op(OP_ARP, 32'hC0A8_0002, 48'h0011_2233_4455, 32'hC0A8_0001, 1'b1);
		send_op(OP_ARP, 32'hC0A8_0003, 48'hFFFF_FFFF_FFFE, 32'h0, 1'b0);
		send_op(OP_ARP, 32'hC0A8_0002, 48'h0, 32'h0, 1'b1);
		send_op(OP_ARP, 32'hFFFF_FFFF, 48'hAAAA_5555_AAAA, 32'h1234_5678, 1'b1);
		send_op(OP_FILL, 32'hC0A8_0002, '0, '0, 1'b0);
		send_op(OP_FILL, 32'h0, '1, '1, 1'b1);
		send_op(OP_FILL, 32'h0, '0, '0, 1'b0);
		send_op(OP_LOOKUP, 32'hC0A8_0002, '0, '0, 1'b0);
		send_op(OP_LOOKUP, 32'h0, '0, '0, 1'b0);
		send_op(OP_LOOKUP, 32'hDEAD_BEEF, '1, '1, 1'b1);
		repeat (8)
			send_op(OP_TICK, 32'hFFFF_FFFF, '1, '1, 1'b1);
	endtask

	task automatic test_table_full();
		set_config(32'h0A00_0001, 16'hFFFF, 16'd2, 8'hFF);
		for (int i = 0; i < DEPTH; i++)
			send_op(OP_FILL, 32'h0B00_0000 + i, '0, '0, 1'b0);
		send_op(OP_FILL, 32'h0C00_0000, '0, '0, 1'b0);
		send_op(OP_ARP, 32'h0C00_0001, 48'h1, 32'h0A00_0001, 1'b1);
		send_op(OP_TICK, 32'h0, '0, '0, 1'b0);
	endtask

	task automatic test_tick_burst();
		set_config(32'h0A00_0001, 16'd1, 16'd1, 8'd0);
		send_op(OP_TICK, 32'h0, '0, '0, 1'b0);
		send_op(OP_TICK, 32'h0, '0, '0, 1'b0);
		for (int i = 0; i < DEPTH; i++)
			send_op(OP_FILL, 32'h0D00_0000 + i, '0, '0, 1'b0);
		for (int i = 0; i < DEPTH; i++)
			send_op(OP_LOOKUP, 32'h0D00_0000 + i, '0, '0, 1'b0);
		send_op(OP_TICK, 32'h0, '0, '0, 1'b0);
		send_op(OP_TICK, 32'h0, '0, '0, 1'b0);
	endtask

	task automatic test_backpressure();
		set_config(32'h0A00_0001, 16'd100, 16'd5, 8'd3);
		hold_off = 1'b1;
		for (int i = 0; i < 6; i++)
			send_op(OP_LOOKUP, 32'h0E00_0000 + i, '0, '0, 1'b0);
	endtask

	task automatic test_random(input int count);
		logic [31:0] ip, tip;
		logic [1:0] op;
		for (int n = 0; n < count; n++) begin
			if (n % 35 == 0)
				set_config($urandom_range(0, 1) ? ip_pool[0] : $urandom(),
					16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)),
					8'($urandom_range(0, 4)));
			ip = ($urandom_range(0, 4) != 0) ? ip_pool[$urandom_range(0, 7)] : $urandom();
			op = 2'($urandom_range(0, 3));
			tip = $urandom_range(0, 2) == 0 ? 32'h0 :
				($urandom_range(0, 1) ? cfg_my_ip : $urandom());
			send_op(op, ip, 48'({$urandom(), $urandom()}), tip, 1'($urandom_range(0, 1)));
		end
	endtask

	// receiver: random stalls, a long hold-off when requested
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			if ($urandom_range(0, 2) == 0)
				out_ready <= 1'b0;
			else
				out_ready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		out_beat_t exp_b;
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				$display("%0t unexpected beat %h", $realtime, out_data);
				errors++;
			end else begin
				exp_b = expected_beats.pop_front();
				if (out_data.action !== exp_b.action) begin
					$display("%0t action exp %0d got %0d", $realtime, exp_b.action,
						out_data.action);
					errors++;
				end
				if (out_data.ip_out !== exp_b.ip_out) begin
					$display("%0t ip exp %h got %h", $realtime, exp_b.ip_out, out_data.ip_out);
					errors++;
				end
				if (out_data.mac_out !== exp_b.mac_out) begin
					$display("%0t mac exp %h got %h", $realtime, exp_b.mac_out,
						out_data.mac_out);
					errors++;
				end
				if (out_data.last !== exp_b.last) begin
					$display("%0t last exp %b got %b", $realtime, exp_b.last, out_data.last);
					errors++;
				end
			end
		end
	end

	initial begin
		#50_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		cfg_my_ip = '0;
		cfg_entry_exp = 16'd60000;
		cfg_req_exp = 16'd1000;
		cfg_max_req = 8'd3;
		for (int i = 0; i < DEPTH; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_in_use[i] = 1'b0;
			tbl_count[i] = '0;
			tbl_timer[i] = '0;
			tbl_ip[i] = '0;
			tbl_mac[i] = '0;
		end
		for (int i = 0; i < 8; i++)
			ip_pool[i] = $urandom();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_tick_burst();
		test_backpressure();
		test_random(25);
		drain();
		if (errors == 0 && expected_beats.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0t %0d beats left over", $realtime, expected_beats.size());
			$display("simulation failed");
		end
		$finish;
	end
endmodule
